[rtl/core/cnms_pkg.sv]
// Shared types and constants of the Canny non-maximum suppression core.
// Used by the core but its line buffer, and by its checker; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package cnms_pkg;

  localparam int IN_TDATA_W  = 32;
  localparam int OUT_FIELD_W = 18;
  localparam int OUT_TDATA_W = 24;
  localparam int DIM_BITS    = 12;
  localparam int ROW_BITS    = DIM_BITS + 1;
  localparam int CFG_IDX_W   = 1;
  localparam int OUT_MAG_W   = 16;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

  localparam int RESET_WIDTH  = 640;
  localparam int RESET_HEIGHT = 480;

  // Fraction of sqrt(2) in Q0.32; tan(22.5 deg) = sqrt(2) - 1.
  localparam logic [31:0] SQRT2_FRAC_Q32 = 32'h6A09E667;

  typedef enum logic [1:0] {
    DIR_HORZ      = 2'd0,
    DIR_DIAG_MAIN = 2'd1,
    DIR_VERT      = 2'd2,
    DIR_DIAG_ANTI = 2'd3
  } dir_bin_t;

  typedef struct packed {
    logic up;
    logic dn;
    logic lf;
    logic rt;
  } nbr_flags_t;

endpackage

`default_nettype wire

[rtl/core/cnms_line_buf.sv]
// Line buffer memory: one write and one registered read per cycle.
// A read of the address written in the same cycle returns the new data.
`timescale 1ns / 1ps
`default_nettype none

module cnms_line_buf #(
  parameter int DEPTH  = 2048,
  parameter int DATA_W = 36
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [DATA_W-1:0]        rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [DATA_W-1:0]        wr_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data <= wr_data;
      end else begin
        rd_data <= mem[rd_addr];
      end
    end
  end

endmodule

`default_nettype wire

[rtl/core/cnms_dir_bin.sv]
// Sorts a signed fixed-point gradient slope into one of four direction bins.
// Depends on cnms_pkg for the bin codes and the sqrt(2) constant.
`timescale 1ns / 1ps
`default_nettype none

module cnms_dir_bin #(
  parameter int SLOPE_FRAC_BITS = 8
) (
  input  logic signed [15:0]  slope,
  output cnms_pkg::dir_bin_t  dir_bin
);

  import cnms_pkg::*;

  localparam int T1 = int'(SQRT2_FRAC_Q32 >> (32 - SLOPE_FRAC_BITS));
  localparam int T2 = (2 << SLOPE_FRAC_BITS) + T1;

  logic signed [31:0] s_ext;

  assign s_ext = 32'(slope);

  always_comb begin
    priority if ((s_ext > T2) || (s_ext < -T2)) begin
      dir_bin = DIR_VERT;
    end else if (s_ext > T1) begin
      dir_bin = DIR_DIAG_MAIN;
    end else if (s_ext < -T1) begin
      dir_bin = DIR_DIAG_ANTI;
    end else begin
      dir_bin = DIR_HORZ;
    end
  end

endmodule

`default_nettype wire

[rtl/core/cnms_judge.sv]
// Suppression decision for the centre of a 3x3 window along its direction bin.
// Depends on cnms_pkg for the bin codes and the neighbor flag struct.
`timescale 1ns / 1ps
`default_nettype none

module cnms_judge #(
  parameter int MB = 16
) (
  input  logic [MB-1:0]          centre_mag,
  input  cnms_pkg::dir_bin_t     centre_bin,
  input  cnms_pkg::nbr_flags_t   flags,
  input  logic [MB-1:0]          nw_mag,
  input  logic [MB-1:0]          n_mag,
  input  logic [MB-1:0]          ne_mag,
  input  logic [MB-1:0]          w_mag,
  input  logic [MB-1:0]          e_mag,
  input  logic [MB-1:0]          sw_mag,
  input  logic [MB-1:0]          s_mag,
  input  logic [MB-1:0]          se_mag,
  output logic [MB-1:0]          kept_mag
);

  import cnms_pkg::*;

  logic kill;

  always_comb begin
    kill = 1'b0;
    unique case (centre_bin)
      DIR_HORZ: begin
        if (flags.lf && (centre_mag <= w_mag)) kill = 1'b1;
        if (flags.rt && (centre_mag <= e_mag)) kill = 1'b1;
      end
      DIR_DIAG_MAIN: begin
        if (flags.up && flags.lf && (centre_mag <= nw_mag)) kill = 1'b1;
        if (flags.dn && flags.rt && (centre_mag <= se_mag)) kill = 1'b1;
      end
      DIR_VERT: begin
        if (flags.up && (centre_mag <= n_mag)) kill = 1'b1;
        if (flags.dn && (centre_mag <= s_mag)) kill = 1'b1;
      end
      DIR_DIAG_ANTI: begin
        if (flags.up && flags.rt && (centre_mag <= ne_mag)) kill = 1'b1;
        if (flags.dn && flags.lf && (centre_mag <= sw_mag)) kill = 1'b1;
      end
    endcase
    kept_mag = kill ? '0 : centre_mag;
  end

endmodule

`default_nettype wire

[rtl/core/canny_non_max_suppression_core.sv]
// Canny non-maximum suppression over a raster-order pixel stream, built on
// cnms_pkg, cnms_line_buf, cnms_dir_bin and cnms_judge.
//
// The core takes one word per clock unless the output stalls and gives at most
// one result per word, with an input register and a result register between
// the two sides. The sustained rate of one word per cycle is set by the line
// buffer, which does one read and one write each cycle. The result for a pixel
// comes out with the word that arrives width+1 words later, so a frame takes
// width*(height+1)+1 words: after the last pixel the host sends width+1 flush
// words. The flush flag in tuser is not looked at; only the position in the
// frame counts. The line buffer has no clearing pass after reset, since data
// read before it was written never reaches a result. Writing either register
// restarts the frame and must be done only while no result is outstanding.
`timescale 1ns / 1ps
`default_nettype none

module canny_non_max_suppression_core #(
  parameter int MAX_WIDTH       = 2048,
  parameter int MAG_BITS        = 16,
  parameter int SLOPE_FRAC_BITS = 8
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // Fields from bit 0: magnitude[15:0], slope[15:0].
  input  logic [cnms_pkg::IN_TDATA_W-1:0]      in_tdata,
  // Fields from bit 0: pad.
  input  logic                                 in_tuser,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // Fields from bit 0: magnitude_out[15:0], direction_bin[1:0], zero fill.
  output logic [cnms_pkg::OUT_TDATA_W-1:0]     out_tdata,
  output logic                                 out_tlast,
  input  logic                                 cfg_wr_en,
  input  logic [cnms_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [cnms_pkg::DIM_BITS-1:0]        cfg_data
);

  import cnms_pkg::*;

  localparam int MB      = (MAG_BITS < OUT_MAG_W) ? MAG_BITS : OUT_MAG_W;
  localparam int CELL_W  = MB + 2;
  localparam int CW      = $clog2(MAX_WIDTH);
  localparam int WW      = $clog2(MAX_WIDTH + 1);
  localparam int RST_W   = (RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RESET_WIDTH;

  logic [WW-1:0]       width_r;
  logic [DIM_BITS-1:0] height_r;
  logic [CW-1:0]       col_r;
  logic [ROW_BITS-1:0] row_r;

  logic                s1_valid_r;
  logic [MB-1:0]       s1_mag_r;
  logic signed [15:0]  s1_slope_r;
  logic [CW-1:0]       s1_col_r;
  logic [ROW_BITS-1:0] s1_row_r;

  logic [CELL_W-1:0]   win_r [9];

  logic                out_valid_r;
  logic [OUT_MAG_W-1:0] out_mag_r;
  dir_bin_t            out_bin_r;
  logic                out_last_r;

  logic                in_acc;
  logic                s1_adv;
  logic [ROW_BITS-1:0] h13;
  logic [ROW_BITS-1:0] h1;
  logic [WW-1:0]       col_inc;
  logic                pos_restart;
  logic [31:0]         cfg_w32;

  logic [2*CELL_W-1:0] lb_rd;
  logic [CELL_W-1:0]   lb_top;
  logic [CELL_W-1:0]   lb_mid;
  dir_bin_t            s1_bin;
  logic [CELL_W-1:0]   s1_cell;

  logic                is_a;
  logic                is_b;
  logic                last_hit;
  nbr_flags_t          flags;
  logic [MB-1:0]       kept_mag;

  assign in_acc    = in_tvalid && in_tready;
  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;

  assign h13         = {1'b0, height_r};
  assign h1          = h13 + ROW_BITS'(1);
  assign col_inc     = WW'(col_r) + WW'(1);
  assign pos_restart = (col_r == '0) && (row_r >= h1);

  always_comb begin
    if (cfg_data == '0) begin
      cfg_w32 = 32'd1;
    end else if (32'(cfg_data) > 32'(MAX_WIDTH)) begin
      cfg_w32 = 32'(MAX_WIDTH);
    end else begin
      cfg_w32 = 32'(cfg_data);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WW'(RST_W);
      height_r <= DIM_BITS'(RESET_HEIGHT);
      col_r    <= '0;
      row_r    <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  width_r  <= cfg_w32[WW-1:0];
        REG_IMAGE_HEIGHT: height_r <= (cfg_data == '0) ? DIM_BITS'(1) : cfg_data;
      endcase
      col_r <= '0;
      row_r <= '0;
    end else if (in_acc) begin
      if (pos_restart) begin
        col_r <= '0;
        row_r <= '0;
      end else if (col_inc >= width_r) begin
        col_r <= '0;
        row_r <= row_r + ROW_BITS'(1);
      end else begin
        col_r <= col_inc[CW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_mag_r   <= in_tdata[MB-1:0];
      s1_slope_r <= in_tdata[31:16];
      s1_col_r   <= col_r;
      s1_row_r   <= row_r;
    end
  end

  cnms_line_buf #(
    .DEPTH  (MAX_WIDTH),
    .DATA_W (2 * CELL_W)
  ) u_line_buf (
    .clk     (clk),
    .rd_en   (in_acc),
    .rd_addr (col_r),
    .rd_data (lb_rd),
    .wr_en   (s1_adv),
    .wr_addr (s1_col_r),
    .wr_data ({lb_mid, s1_cell})
  );

  assign lb_top = lb_rd[2*CELL_W-1:CELL_W];
  assign lb_mid = lb_rd[CELL_W-1:0];

  cnms_dir_bin #(
    .SLOPE_FRAC_BITS (SLOPE_FRAC_BITS)
  ) u_dir_bin (
    .slope   (s1_slope_r),
    .dir_bin (s1_bin)
  );

  assign s1_cell = {s1_bin, s1_mag_r};

  // The column that wraps the row is judged before the window shifts; the
  // right-hand neighbor is then outside the frame, so the same taps serve both.
  always_comb begin
    is_a     = (s1_col_r == '0) && (s1_row_r >= ROW_BITS'(2)) && (s1_row_r <= h1);
    is_b     = (s1_col_r != '0) && (s1_row_r >= ROW_BITS'(1)) && (s1_row_r <= h13);
    last_hit = is_a && (s1_row_r == h1);
    if (s1_col_r == '0) begin
      flags.up = s1_row_r >= ROW_BITS'(3);
      flags.dn = s1_row_r <= h13;
      flags.lf = width_r > WW'(1);
      flags.rt = 1'b0;
    end else begin
      flags.up = s1_row_r >= ROW_BITS'(2);
      flags.dn = s1_row_r < h13;
      flags.lf = s1_col_r >= CW'(2);
      flags.rt = WW'(s1_col_r) < width_r;
    end
  end

  cnms_judge #(
    .MB (MB)
  ) u_judge (
    .centre_mag (win_r[5][MB-1:0]),
    .centre_bin (dir_bin_t'(win_r[5][CELL_W-1:MB])),
    .flags      (flags),
    .nw_mag     (win_r[1][MB-1:0]),
    .n_mag      (win_r[2][MB-1:0]),
    .ne_mag     (lb_top[MB-1:0]),
    .w_mag      (win_r[4][MB-1:0]),
    .e_mag      (lb_mid[MB-1:0]),
    .sw_mag     (win_r[7][MB-1:0]),
    .s_mag      (win_r[8][MB-1:0]),
    .se_mag     (s1_cell[MB-1:0]),
    .kept_mag   (kept_mag)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 9; i++) begin
        win_r[i] <= '0;
      end
    end else if (s1_adv) begin
      for (int i = 0; i < 3; i++) begin
        win_r[i*3]     <= win_r[i*3 + 1];
        win_r[i*3 + 1] <= win_r[i*3 + 2];
      end
      win_r[2] <= lb_top;
      win_r[5] <= lb_mid;
      win_r[8] <= s1_cell;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= is_a || is_b;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_mag_r  <= OUT_MAG_W'(kept_mag);
      out_bin_r  <= dir_bin_t'(win_r[5][CELL_W-1:MB]);
      out_last_r <= last_hit;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W - OUT_FIELD_W){1'b0}}, out_bin_r, out_mag_r};
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire

[rtl/core/cnms_checker.sv]
// Port-level checks of the non-maximum suppression core, bound to its top level.
// Depends on cnms_pkg for the word widths.
`timescale 1ns / 1ps
`default_nettype none

module cnms_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tready,
  input  logic                              out_tvalid,
  input  logic                              out_tready,
  input  logic [cnms_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input  logic                              out_tlast
);

  import cnms_pkg::*;

  // A reset leaves no result pending.
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // Input backpressure only comes from a stalled, full result register.
  a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_tvalid && !out_tready))
    else $error("input stalled while the result side is free");

  a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> out_tvalid)
    else $error("result dropped while stalled");

  a_data_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> ($stable(out_tdata) && $stable(out_tlast)))
    else $error("result word changed while stalled");

endmodule

bind canny_non_max_suppression_core cnms_checker u_cnms_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

`default_nettype wire

[verif/testbench.sv]
// Self-checking testbench for canny_non_max_suppression_core; uses cnms_pkg.
// Words go in with random bursts and gaps, results are drained under a changing
// stall pattern; each result is checked by a local predictor or a typed value.
`timescale 1ns / 1ps

module testbench;
  import cnms_pkg::*;

  localparam int SPAN        = 2048;
  localparam int TAN_LO      = int'(SQRT2_FRAC_Q32 >> 24);
  localparam int TAN_HI      = 512 + TAN_LO;
  localparam int SETTLE      = 16;
  localparam int STALL_LIMIT = 4000;

  typedef struct packed {
    dir_bin_t    bin;
    logic [15:0] mag;
  } pix_t;

  typedef struct packed {
    logic [15:0] mag;
    dir_bin_t    bin;
    logic        last;
  } nms_res_t;

  typedef struct packed {
    logic [15:0] mag;
    logic [15:0] slope;
    logic        pad;
    logic        typed;
    nms_res_t    want;
  } probe_t;

  typedef struct packed {
    logic [11:0] w;
    logic [11:0] h;
    int          count;
  } shape_t;

  logic                 clk;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [IN_TDATA_W-1:0] in_tdata  = '0;
  logic                 in_tuser   = 1'b0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                 out_tlast;
  logic                 cfg_wr_en  = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index  = REG_IMAGE_WIDTH;
  logic [DIM_BITS-1:0]  cfg_data   = '0;

  pix_t     upper_row [SPAN];
  pix_t     middle_row [SPAN];
  pix_t     win [9];
  int       col_pos;
  int       row_pos;
  int       img_w;
  int       img_h;
  nms_res_t pending [$];
  probe_t   probes [24];
  shape_t   shapes [10];
  int       errors      = 0;
  int       words_out   = 0;
  int       idle_cycles = 0;
  int       burst_left  = 0;
  int       rx_tick     = 0;
  int       rx_mode     = 0;

  canny_non_max_suppression_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic dir_bin_t slope_bin(input logic [15:0] raw);
    int s;
    s = int'($signed(raw));
    if (s > TAN_HI || s < -TAN_HI) return DIR_VERT;
    if (s > TAN_LO) return DIR_DIAG_MAIN;
    if (s < -TAN_LO) return DIR_DIAG_ANTI;
    return DIR_HORZ;
  endfunction

  // Judges the center cell of window column cc; x and y place it in the frame.
  function automatic logic [15:0] suppress(input int lc, input int cc, input int rc,
                                           input int x, input int y, output dir_bin_t b);
    logic [15:0] m;
    bit up, dn, lf, rt, kill;
    m    = win[3 + cc].mag;
    b    = win[3 + cc].bin;
    up   = y > 0;
    dn   = y + 1 < img_h;
    lf   = x > 0;
    rt   = x + 1 < img_w;
    case (b)
      DIR_HORZ: begin
        kill = (lf && m <= win[3 + lc].mag) || (rt && m <= win[3 + rc].mag);
      end
      DIR_DIAG_MAIN: begin
        kill = (up && lf && m <= win[lc].mag) || (dn && rt && m <= win[6 + rc].mag);
      end
      DIR_VERT: begin
        kill = (up && m <= win[cc].mag) || (dn && m <= win[6 + cc].mag);
      end
      default: begin
        kill = (up && rt && m <= win[rc].mag) || (dn && lf && m <= win[6 + lc].mag);
      end
    endcase
    return kill ? 16'h0000 : m;
  endfunction

  function automatic bit predict_word(input logic [15:0] mag, input logic [15:0] slp,
                                      output nms_res_t res);
    pix_t     pix;
    pix_t     top;
    pix_t     mid;
    dir_bin_t b;
    bit       got;
    int       c;
    int       r;
    c         = col_pos;
    r         = row_pos;
    got       = 1'b0;
    res       = '0;
    pix.mag   = mag;
    pix.bin   = slope_bin(slp);
    top       = upper_row[c];
    mid       = middle_row[c];
    upper_row[c]  = mid;
    middle_row[c] = pix;
    // A word in the first column finishes the last pixel of the row two above.
    if (c == 0 && r >= 2 && r <= img_h + 1) begin
      res.mag  = suppress(1, 2, 2, img_w - 1, r - 2, b);
      res.bin  = b;
      res.last = (r == img_h + 1);
      got      = 1'b1;
    end
    for (int i = 0; i < 3; i++) begin
      win[i * 3]     = win[i * 3 + 1];
      win[i * 3 + 1] = win[i * 3 + 2];
    end
    win[2] = top;
    win[5] = mid;
    win[8] = pix;
    if (c != 0 && r >= 1 && r <= img_h) begin
      res.mag  = suppress(0, 1, 2, c - 1, r - 1, b);
      res.bin  = b;
      res.last = 1'b0;
      got      = 1'b1;
    end
    if (c == 0 && r >= img_h + 1) begin
      col_pos = 0;
      row_pos = 0;
    end else begin
      c++;
      if (c >= img_w) begin
        c = 0;
        r++;
      end
      col_pos = c;
      row_pos = r;
    end
    return got;
  endfunction

  function automatic void set_geometry(input logic [11:0] w, input logic [11:0] h);
    img_w   = (w == 0) ? 1 : ((w > SPAN) ? SPAN : int'(w));
    img_h   = (h == 0) ? 1 : int'(h);
    col_pos = 0;
    row_pos = 0;
  endfunction

  function automatic void reset_predictor();
    for (int i = 0; i < SPAN; i++) begin
      upper_row[i]  = '0;
      middle_row[i] = '0;
    end
    for (int i = 0; i < 9; i++) win[i] = '0;
    img_w   = RESET_WIDTH;
    img_h   = RESET_HEIGHT;
    col_pos = 0;
    row_pos = 0;
  endfunction

  function automatic logic [15:0] pick_mag();
    case ($urandom_range(0, 2))
      0:       return 16'($urandom);
      1:       return 16'($urandom_range(0, 3));
      default: return $urandom_range(0, 1) ? 16'hFFFF : 16'hFFFE;
    endcase
  endfunction

  function automatic logic [15:0] pick_slope();
    case ($urandom_range(0, 3))
      0: begin
        case ($urandom_range(0, 10))
          0:       return 16'h006A;
          1:       return 16'h006B;
          2:       return 16'h026A;
          3:       return 16'h026B;
          4:       return 16'hFF96;
          5:       return 16'hFF95;
          6:       return 16'hFD96;
          7:       return 16'hFD95;
          8:       return 16'h7FFF;
          9:       return 16'h8000;
          default: return 16'h0000;
        endcase
      end
      1:       return 16'($urandom);
      default: return 16'(int'($urandom_range(0, 1600)) - 800);
    endcase
  endfunction

  task automatic report(input string what, input int got, input int want);
    $display("%s mismatch on result word %0d: got %0h, expected %0h",
             what, words_out, got, want);
    errors++;
  endtask

  task automatic send_word(input logic [15:0] mag, input logic [15:0] slp, input logic pad,
                           input logic typed, input nms_res_t want);
    nms_res_t res;
    bit       got;
    int       gap;
    in_tvalid <= 1'b1;
    in_tdata  <= {slp, mag};
    in_tuser  <= pad;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    got = predict_word(mag, slp, res);
    if (typed) pending.push_back(want);
    else if (got) pending.push_back(res);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Mostly well-formed frames: the pad flag follows the position, with some noise.
  task automatic send_random(input int count);
    bit flush;
    repeat (count) begin
      flush = row_pos >= img_h;
      send_word(pick_mag(), pick_slope(), flush ^ ($urandom_range(0, 15) == 0), 1'b0, '0);
    end
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_geometry(input logic [11:0] w, input logic [11:0] h);
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_IMAGE_WIDTH;
    cfg_data  <= w;
    @(posedge clk);
    cfg_index <= REG_IMAGE_HEIGHT;
    cfg_data  <= h;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    set_geometry(w, h);
  endtask

  always @(posedge clk) begin
    nms_res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending.size() == 0) begin
        report("unexpected", int'(out_tdata), 0);
      end else begin
        want = pending.pop_front();
        if (out_tdata[15:0] != want.mag) report("magnitude", out_tdata[15:0], want.mag);
        if (out_tdata[17:16] != want.bin) report("direction", out_tdata[17:16], want.bin);
        if (out_tlast != want.last) report("last", out_tlast, want.last);
      end
      words_out++;
    end
    rx_tick++;
    if (rx_tick % 48 == 0) rx_mode = $urandom_range(0, 3);
    case (rx_mode)
      0:       out_tready <= 1'b1;
      1:       out_tready <= ($urandom_range(0, 3) != 0);
      2:       out_tready <= ($urandom_range(0, 3) == 0);
      default: out_tready <= ((rx_tick / 4) % 2 == 0);
    endcase
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles == STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    reset_predictor();
    // One-pixel frames: pixel, then two flush words; the second gives the result.
    probes = '{
      '{16'hFFFF, 16'h0000, 1'b0, 1'b0, '{16'h0000, DIR_HORZ, 1'b0}},
      '{16'hAAAA, 16'h5555, 1'b1, 1'b0, '{16'h0000, DIR_HORZ, 1'b0}},
      '{16'h5555, 16'hAAAA, 1'b1, 1'b1, '{16'hFFFF, DIR_HORZ, 1'b1}},
      '{16'h0000, 16'h7FFF, 1'b0, 1'b0, '{16'h0000, DIR_HORZ, 1'b0}},
      '{16'h0000, 16'h0000, 1'b1, 1'b0, '{16'h0000, DIR_HORZ, 1'b0}},
      '{16'h0000, 16'h0000, 1'b1, 1'b1, '{16'h0000, DIR_VERT, 1'b1}},
      '{16'h0001, 16'h8000, 1'b1, 1'b0, '{16'h0000, DIR_HORZ, 1'b0}},
      '{16'hFFFF, 16'hFFFF, 1'b1, 1'b0, '{16'h0000, DIR_HORZ, 1'b0}},
      '{16'hFFFF, 16'hFFFF, 1'b1, 1'b1, '{16'h0001, DIR_VERT, 1'b1}},
      '{16'h1234, 16'h006A, 1'b0, 1'b0, '{16'h0000, DIR_HORZ, 1'b0}},
      '{16'h0F0F, 16'hF0F0, 1'b1, 1'b0, '{16'h0000, DIR_HORZ, 1'b0}},
      '{16'hF0F0, 16'h0F0F, 1'b1, 1'b1, '{16'h1234, DIR_HORZ, 1'b1}},
      '{16'h5678, 16'h006B, 1'b0, 1'b0, '{16'h0000, DIR_HORZ, 1'b0}},
      '{16'h0000, 16'h0000, 1'b1, 1'b0, '{16'h0000, DIR_HORZ, 1'b0}},
      '{16'h0000, 16'h0000, 1'b1, 1'b1, '{16'h5678, DIR_DIAG_MAIN, 1'b1}},
      '{16'h9ABC, 16'h026A, 1'b0, 1'b0, '{16'h0000, DIR_HORZ, 1'b0}},
      '{16'h0000, 16'h0000, 1'b1, 1'b0, '{16'h0000, DIR_HORZ, 1'b0}},
      '{16'h0000, 16'h0000, 1'b1, 1'b1, '{16'h9ABC, DIR_DIAG_MAIN, 1'b1}},
      '{16'hDEF0, 16'hFF95, 1'b0, 1'b0, '{16'h0000, DIR_HORZ, 1'b0}},
      '{16'hFFFF, 16'hFFFF, 1'b0, 1'b0, '{16'h0000, DIR_HORZ, 1'b0}},
      '{16'h0000, 16'h0000, 1'b1, 1'b1, '{16'hDEF0, DIR_DIAG_ANTI, 1'b1}},
      '{16'hF0F0, 16'hFD95, 1'b0, 1'b0, '{16'h0000, DIR_HORZ, 1'b0}},
      '{16'h0000, 16'h0000, 1'b1, 1'b0, '{16'h0000, DIR_HORZ, 1'b0}},
      '{16'h0000, 16'h0000, 1'b1, 1'b1, '{16'hF0F0, DIR_VERT, 1'b1}}
    };
    // The 7x1 run stops inside a frame, so the next write restarts it.
    shapes = '{
      '{12'd4095, 12'd1,    20},
      '{12'd1,    12'd4095, 20},
      '{12'd3,    12'd3,    26},
      '{12'd5,    12'd4,    26},
      '{12'd8,    12'd4,    41},
      '{12'd12,   12'd3,    49},
      '{12'd2,    12'd9,    42},
      '{12'd7,    12'd1,    23},
      '{12'd1,    12'd5,    14},
      '{12'd9,    12'd5,    55}
    };
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    send_random(650);
    drain();
    write_geometry(12'd0, 12'd0);
    foreach (probes[i]) begin
      send_word(probes[i].mag, probes[i].slope, probes[i].pad, probes[i].typed, probes[i].want);
    end
    foreach (shapes[i]) begin
      drain();
      write_geometry(shapes[i].w, shapes[i].h);
      send_random(shapes[i].count);
    end
    drain();
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[canny_non_max_suppression_core.f]
rtl/core/cnms_pkg.sv
rtl/core/cnms_line_buf.sv
rtl/core/cnms_dir_bin.sv
rtl/core/cnms_judge.sv
rtl/core/canny_non_max_suppression_core.sv
rtl/core/cnms_checker.sv
verif/testbench.sv
